FILE: design/etp_pkg.sv
// Shared types and constants of the exclusive time profiler.
package etp_pkg;

  localparam int ID_W     = 8;
  localparam int MODE_W   = 2;
  localparam int EVT_W    = 32;
  localparam int TOTAL_W  = 48;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_END   = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_STACK_OVF = 2'd1,
    ST_STACK_UNF = 2'd2,
    ST_TOTAL_OVF = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_END_DUR,
    S_END_ADD,
    S_END_SUB
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic load_rd;
    logic end_dur;
    logic end_add;
    logic end_commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic end_go;
  } dp_stat_t;

endpackage

FILE: design/etp_ctrl.sv
// Sequencer of the exclusive time profiler: handshakes and datapath commands.
module etp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  etp_pkg::dp_stat_t   st,
  output etp_pkg::ctrl_cmd_t  cmd
);
  import etp_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = st.end_go ? S_END_DUR : S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd.load_rd    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_END_DUR: begin
        cmd.end_dur = 1'b1;
        state_next  = S_END_ADD;
      end
      S_END_ADD: begin
        cmd.end_add = 1'b1;
        state_next  = S_END_SUB;
      end
      S_END_SUB: begin
        if (out_free) begin
          cmd.end_commit = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: design/etp_datapath.sv
// Datapath of the exclusive time profiler: call stack, totals memory and result register.
module etp_datapath #(
  parameter int MAX_FUNCTIONS = 256,
  parameter int STACK_DEPTH   = 64,
  parameter int TIME_BITS     = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  etp_pkg::ctrl_cmd_t                 cmd,
  output etp_pkg::dp_stat_t                  st,
  input  logic [etp_pkg::MODE_W-1:0]         mode,
  input  logic [etp_pkg::ID_W-1:0]           function_id,
  input  logic [etp_pkg::EVT_W-1:0]          event_time,
  output logic [etp_pkg::ID_W-1:0]           result_id,
  output logic signed [etp_pkg::TOTAL_W-1:0] exclusive_total,
  output logic [etp_pkg::STATUS_W-1:0]       status
);
  import etp_pkg::*;

  localparam int TW    = (TIME_BITS < EVT_W) ? TIME_BITS : EVT_W;
  localparam int DW    = TW + 2;
  localparam int SW    = TOTAL_W + 2;
  localparam int FA_W  = (MAX_FUNCTIONS > 1) ? $clog2(MAX_FUNCTIONS) : 1;
  localparam int SP_W  = $clog2(STACK_DEPTH);
  localparam int LV_W  = $clog2(STACK_DEPTH + 1);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  function automatic logic [FA_W-1:0] fold_id(input logic [ID_W-1:0] v);
    logic [31:0] r;
    r = {{(32-ID_W){1'b0}}, v};
    for (int i = ID_W - 1; i >= 0; i--) begin
      if (r >= (32'(MAX_FUNCTIONS) << i)) begin
        r = r - (32'(MAX_FUNCTIONS) << i);
      end
    end
    return r[FA_W-1:0];
  endfunction

  function automatic logic [TOTAL_W:0] sat_add(input logic [TOTAL_W-1:0] a,
                                               input logic [DW-1:0] d,
                                               input logic neg);
    logic [SW-1:0] a_ext;
    logic [SW-1:0] d_ext;
    logic [SW-1:0] s;
    logic          ovf;
    a_ext = {{(SW-TOTAL_W){a[TOTAL_W-1]}}, a};
    d_ext = {{(SW-DW){d[DW-1]}}, d};
    s     = neg ? (a_ext - d_ext) : (a_ext + d_ext);
    ovf   = (s[SW-1:TOTAL_W-1] != {(SW-TOTAL_W+1){1'b0}}) &&
            (s[SW-1:TOTAL_W-1] != {(SW-TOTAL_W+1){1'b1}});
    if (ovf) begin
      return {1'b1, (s[SW-1] ? TOTAL_MIN : TOTAL_MAX)};
    end
    return {1'b0, s[TOTAL_W-1:0]};
  endfunction

  logic [ID_W-1:0]    ids_mem   [STACK_DEPTH];
  logic [TW-1:0]      times_mem [STACK_DEPTH];
  logic [TOTAL_W-1:0] tot_mem   [MAX_FUNCTIONS];

  logic [LV_W-1:0]    level;
  logic [FA_W-1:0]    clr_addr;
  logic               stack_full;
  logic               push;
  logic               pop;
  logic [SP_W-1:0]    top_addr;
  logic [SP_W-1:0]    prev_addr;
  logic [FA_W-1:0]    idx_in;
  logic [FA_W-1:0]    prev_idx;

  logic [ID_W-1:0]    fid_r;
  logic [TW-1:0]      t_r;
  logic [FA_W-1:0]    idx_r;
  logic [FA_W-1:0]    prev_idx_r;
  logic               has_prev;
  status_t            pend_status;
  logic [TW-1:0]      top_time;
  logic [ID_W-1:0]    prev_id;
  logic [DW-1:0]      dur;
  logic [TOTAL_W-1:0] acc;
  logic [TOTAL_W-1:0] sum_idx;
  logic               ovf_idx;
  logic [TOTAL_W-1:0] prev_base;

  logic               tot_we;
  logic [FA_W-1:0]    tot_waddr;
  logic [TOTAL_W-1:0] tot_wdata;
  logic               tot_re;
  logic [FA_W-1:0]    tot_raddr;
  logic [TOTAL_W-1:0] tot_rdata;

  logic [TOTAL_W:0]   add_res;
  logic [TOTAL_W:0]   sub_res;
  logic               same_id;

  assign stack_full = (level == LV_W'(STACK_DEPTH));
  assign st.end_go  = (mode == MODE_END) && (level != '0);
  assign st.clr_last = (clr_addr == FA_W'(MAX_FUNCTIONS - 1));
  assign push       = cmd.accept && (mode == MODE_START) && !stack_full;
  assign pop        = cmd.accept && st.end_go;
  assign top_addr   = level[SP_W-1:0] - SP_W'(1);
  assign prev_addr  = level[SP_W-1:0] - SP_W'(2);
  assign idx_in     = fold_id(function_id);
  assign prev_idx   = fold_id(prev_id);
  assign same_id    = (prev_idx_r == idx_r);
  assign add_res    = sat_add(acc, dur, 1'b0);
  assign sub_res    = sat_add(prev_base, dur, 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= '0;
      clr_addr <= '0;
    end else begin
      if (push) begin
        level <= level + LV_W'(1);
      end else if (pop) begin
        level <= level - LV_W'(1);
      end
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + FA_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ids_mem[level[SP_W-1:0]]   <= function_id;
      times_mem[level[SP_W-1:0]] <= event_time[TW-1:0];
    end
    if (cmd.accept) begin
      top_time <= times_mem[top_addr];
      prev_id  <= ids_mem[prev_addr];
    end
  end

  always_comb begin
    tot_we    = 1'b0;
    tot_waddr = clr_addr;
    tot_wdata = '0;
    priority if (cmd.clr_wr) begin
      tot_we = 1'b1;
    end else if (cmd.end_add) begin
      tot_we    = 1'b1;
      tot_waddr = idx_r;
      tot_wdata = add_res[TOTAL_W-1:0];
    end else if (cmd.end_commit && has_prev) begin
      tot_we    = 1'b1;
      tot_waddr = prev_idx_r;
      tot_wdata = sub_res[TOTAL_W-1:0];
    end
    tot_re    = cmd.accept || cmd.end_dur;
    tot_raddr = cmd.accept ? idx_in : prev_idx;
  end

  always_ff @(posedge clk) begin
    if (tot_we) begin
      tot_mem[tot_waddr] <= tot_wdata;
    end
    if (tot_re) begin
      tot_rdata <= tot_mem[tot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fid_r    <= function_id;
      t_r      <= event_time[TW-1:0];
      idx_r    <= idx_in;
      has_prev <= (level >= LV_W'(2));
      if ((mode == MODE_START) && stack_full) begin
        pend_status <= ST_STACK_OVF;
      end else if ((mode == MODE_END) && (level == '0)) begin
        pend_status <= ST_STACK_UNF;
      end else begin
        pend_status <= ST_OK;
      end
    end
    if (cmd.end_dur) begin
      dur        <= {2'b00, t_r} - {2'b00, top_time} + DW'(1);
      acc        <= tot_rdata;
      prev_idx_r <= prev_idx;
    end
    if (cmd.end_add) begin
      sum_idx   <= add_res[TOTAL_W-1:0];
      ovf_idx   <= add_res[TOTAL_W];
      prev_base <= same_id ? add_res[TOTAL_W-1:0] : tot_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rd) begin
      result_id       <= fid_r;
      exclusive_total <= tot_rdata;
      status          <= pend_status;
    end else if (cmd.end_commit) begin
      result_id       <= fid_r;
      exclusive_total <= (has_prev && same_id) ? sub_res[TOTAL_W-1:0] : sum_idx;
      status          <= (ovf_idx || (has_prev && sub_res[TOTAL_W])) ? ST_TOTAL_OVF : ST_OK;
    end
  end

endmodule

FILE: design/exclusive_time_profiler_core.sv
// Top level of the exclusive time profiler: sequencer and datapath.
//
// Each input transfer carries mode, function_id and event_time. A start event
// pushes the id and time on the call stack, if not full; an end event pops it,
// if not empty, adds the duration to the id's total and subtracts it from the
// caller's total. A read returns the id's total. Every input transfer yields
// exactly one output transfer with result_id, exclusive_total and status.
// An end event with a non-empty stack passes through S_END_DUR, S_END_ADD and
// S_END_SUB, a read-modify-write of two entries of the totals memory, which
// takes one read and one write a cycle; any other item passes through S_READ.
// Either path loads the result into the output register in its last state,
// once that register is free. One item is worked on at a time.
// After reset the block sweeps all MAX_FUNCTIONS entries of the totals memory
// to zero, one entry a cycle, and holds in_ready low until the sweep ends.
// The output register holds a finished result while out_ready is low; the
// next input transfer is still taken, and its result waits in the block until
// the output register is free.
module exclusive_time_profiler_core #(
  parameter int MAX_FUNCTIONS = 256,
  parameter int STACK_DEPTH   = 64,
  parameter int TIME_BITS     = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [etp_pkg::MODE_W-1:0]         mode,
  input  logic [etp_pkg::ID_W-1:0]           function_id,
  input  logic [etp_pkg::EVT_W-1:0]          event_time,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [etp_pkg::ID_W-1:0]           result_id,
  output logic signed [etp_pkg::TOTAL_W-1:0] exclusive_total,
  output logic [etp_pkg::STATUS_W-1:0]       status
);
  import etp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  etp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  etp_datapath #(
    .MAX_FUNCTIONS (MAX_FUNCTIONS),
    .STACK_DEPTH   (STACK_DEPTH),
    .TIME_BITS     (TIME_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .mode            (mode),
    .function_id     (function_id),
    .event_time      (event_time),
    .result_id       (result_id),
    .exclusive_total (exclusive_total),
    .status          (status)
  );

endmodule

FILE: design/etp_checker.sv
// Port-level assertions for the exclusive time profiler and their binding.
module etp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [etp_pkg::MODE_W-1:0]         mode,
  input logic [etp_pkg::ID_W-1:0]           function_id,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [etp_pkg::ID_W-1:0]           result_id,
  input logic signed [etp_pkg::TOTAL_W-1:0] exclusive_total,
  input logic [etp_pkg::STATUS_W-1:0]       status
);
  import etp_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_ready))
    else $error("Block is not quiet after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A second transfer was offered while an item is in work.");

  a_rise_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("A new result appeared while the block was still busy.");

  a_short_item_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (mode != MODE_END) && !out_valid) |=>
      ##1 (out_valid && (result_id == $past(function_id, 2))))
    else $error("A start or read result did not appear two cycles after its transfer.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(result_id) && $stable(exclusive_total) && $stable(status)))
    else $error("A stalled result changed or was dropped.");

endmodule

bind exclusive_time_profiler_core etp_checker u_etp_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for the exclusive time profiler core.
`timescale 1ns / 1ps

module tb_top;
  import etp_pkg::*;

  localparam int STACK_DEPTH  = 64;
  localparam int FRAME_W      = $clog2(STACK_DEPTH);
  localparam int DRAIN_CYCLES = 24;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [ID_W-1:0] SPAN_OUTER = 8'd200;
  localparam logic [ID_W-1:0] SPAN_INNER = 8'd201;
  localparam longint TOTAL_MAX = (longint'(1) <<< (TOTAL_W - 1)) - 1;
  localparam longint TOTAL_MIN = -(longint'(1) <<< (TOTAL_W - 1));

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TOTAL_W-1:0] total;
    status_t            st;
  } profile_result_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [MODE_W-1:0]         mode = '0;
  logic [ID_W-1:0]           function_id = '0;
  logic [EVT_W-1:0]          event_time = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [ID_W-1:0]           result_id;
  logic signed [TOTAL_W-1:0] exclusive_total;
  logic [STATUS_W-1:0]       status;

  logic [ID_W-1:0]  frame_ids [STACK_DEPTH];
  logic [EVT_W-1:0] frame_times [STACK_DEPTH];
  int               call_depth = 0;
  longint           func_totals [256];
  profile_result_t  pending_totals [$];

  logic [EVT_W-1:0] trace_clock = '0;
  bit               idle_on = 1'b1;
  int               stall_left = 0;
  int               error_count = 0;
  int               results_checked = 0;
  int               n_starts = 0;
  int               n_ends = 0;
  int               n_reads = 0;
  int               n_status [4] = '{0, 0, 0, 0};

  exclusive_time_profiler_core DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .function_id     (function_id),
    .event_time      (event_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_id       (result_id),
    .exclusive_total (exclusive_total),
    .status          (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit accumulate(input logic [ID_W-1:0] slot, input longint delta);
    longint sum;
    sum = func_totals[slot] + delta;
    if (sum > TOTAL_MAX) begin
      func_totals[slot] = TOTAL_MAX;
      return 1'b1;
    end
    if (sum < TOTAL_MIN) begin
      func_totals[slot] = TOTAL_MIN;
      return 1'b1;
    end
    func_totals[slot] = sum;
    return 1'b0;
  endfunction

  function automatic void predict_profile(input logic [MODE_W-1:0] m,
                                          input logic [ID_W-1:0] id,
                                          input logic [EVT_W-1:0] t);
    longint          span;
    bit              saturated;
    profile_result_t r;
    r.st = ST_OK;
    case (m)
      MODE_START: begin
        n_starts++;
        if (call_depth >= STACK_DEPTH) begin
          r.st = ST_STACK_OVF;
        end else begin
          frame_ids[FRAME_W'(call_depth)] = id;
          frame_times[FRAME_W'(call_depth)] = t;
          call_depth++;
        end
      end
      MODE_END: begin
        n_ends++;
        if (call_depth == 0) begin
          r.st = ST_STACK_UNF;
        end else begin
          call_depth--;
          span = longint'(t) - longint'(frame_times[FRAME_W'(call_depth)]) + 1;
          saturated = accumulate(id, span);
          if (call_depth > 0) begin
            if (accumulate(frame_ids[FRAME_W'(call_depth - 1)], -span)) saturated = 1'b1;
          end
          if (saturated) r.st = ST_TOTAL_OVF;
        end
      end
      default: begin
        n_reads++;
      end
    endcase
    r.id = id;
    r.total = TOTAL_W'(func_totals[id]);
    n_status[r.st]++;
    pending_totals.push_back(r);
  endfunction

  task automatic send_item(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                           input logic [EVT_W-1:0] t);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    function_id <= id;
    event_time  <= t;
    do @(posedge clk); while (!in_ready);
    predict_profile(m, id, t);
  endtask

  task automatic wait_for_results;
    in_valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
  endtask

  task automatic unwind_calls;
    while (call_depth > 0) begin
      trace_clock += $urandom_range(1, 500);
      send_item(MODE_END, frame_ids[FRAME_W'(call_depth - 1)], trace_clock);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    profile_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_totals.size() == 0) begin
        error_count++;
        $display("%0t: result transfer with nothing pending, actual id %0d total %0d status %0d",
                 $time, result_id, exclusive_total, status);
      end else begin
        want = pending_totals.pop_front();
        results_checked++;
        if (result_id !== want.id) begin
          error_count++;
          $display("%0t: result_id mismatch, expected %0d, actual %0d",
                   $time, want.id, result_id);
        end
        if (exclusive_total !== want.total) begin
          error_count++;
          $display("%0t: exclusive_total mismatch for id %0d, expected %0d, actual %0d",
                   $time, want.id, $signed(want.total), exclusive_total);
        end
        if (status !== want.st) begin
          error_count++;
          $display("%0t: status mismatch for id %0d, expected %0d, actual %0d",
                   $time, want.id, want.st, status);
        end
      end
    end
  end

  task automatic test_directed_cases;
    send_item(MODE_READ, 8'd0, 32'd0);
    send_item(MODE_SPARE, 8'd255, 32'hFFFF_FFFF);
    send_item(MODE_END, 8'd5, 32'd0);
    send_item(MODE_START, 8'd0, 32'd0);
    send_item(MODE_START, 8'd255, 32'hFFFF_FFFF);
    send_item(MODE_END, 8'd255, 32'hFFFF_FFFF);
    send_item(MODE_END, 8'd0, 32'hFFFF_FFFF);
    send_item(MODE_START, 8'd7, 32'd100);
    send_item(MODE_END, 8'd7, 32'd50);
    send_item(MODE_START, 8'd8, 32'd10);
    send_item(MODE_END, 8'd8, 32'd9);
    send_item(MODE_START, 8'd9, 32'd1000);
    send_item(MODE_START, 8'd10, 32'd1200);
    send_item(MODE_END, 8'd11, 32'd1300);
    send_item(MODE_END, 8'd9, 32'd2000);
    send_item(MODE_START, 8'hAA, 32'h5555_5555);
    send_item(MODE_START, 8'h55, 32'hAAAA_AAAA);
    send_item(MODE_END, 8'h55, 32'hAAAA_AAAA);
    send_item(MODE_END, 8'hAA, 32'hFFFF_0000);
    send_item(MODE_READ, 8'd7, 32'h1234_5678);
    send_item(MODE_SPARE, 8'd8, 32'd0);
    send_item(MODE_READ, 8'd10, 32'd0);
    send_item(MODE_READ, 8'hAA, 32'd0);
  endtask

  task automatic test_stack_limits;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      send_item(MODE_START, 8'(i * 4 + 1), 32'(i * 1000));
    end
    send_item(MODE_START, 8'd3, 32'd99);
    for (int i = STACK_DEPTH - 1; i >= 0; i--) begin
      send_item(MODE_END, frame_ids[FRAME_W'(call_depth - 1)], 32'(i * 1000 + 2500));
    end
    send_item(MODE_END, 8'd1, 32'd7);
  endtask

  task automatic test_random_trace(input int n_items);
    int               roll;
    int               push_pct;
    logic [ID_W-1:0]  id;
    logic [EVT_W-1:0] t;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) trace_clock += $urandom_range(0, 1 << 20);
      else trace_clock += $urandom_range(0, 300);
      push_pct = (call_depth < 3) ? 75 : (call_depth > 24) ? 25 : 50;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_item(MODE_W'($urandom_range(0, 3)), ID_W'($urandom), $urandom);
      end else if (roll < 18) begin
        id = (call_depth > 0 && roll < 13) ? frame_ids[FRAME_W'(call_depth - 1)]
                                           : ID_W'($urandom);
        send_item((roll % 2 == 0) ? MODE_READ : MODE_SPARE, id, $urandom);
      end else if (call_depth == 0 || $urandom_range(0, 99) < push_pct) begin
        id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(16, 31));
        send_item(MODE_START, id, trace_clock);
      end else begin
        id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : frame_ids[FRAME_W'(call_depth - 1)];
        t = ($urandom_range(0, 14) == 0) ? $urandom : trace_clock;
        send_item(MODE_END, id, t);
      end
    end
    unwind_calls();
  endtask

  task automatic test_large_spans;
    logic [EVT_W-1:0] t0;
    logic [EVT_W-1:0] t1;
    idle_on = 1'b0;
    send_item(MODE_START, SPAN_OUTER, 32'd0);
    for (int rounds = 0; rounds < 24; rounds++) begin
      t0 = (rounds % 3 == 2) ? 32'hFFFF_FFFF : 32'd0;
      t1 = ~t0;
      send_item(MODE_START, SPAN_INNER, t0);
      send_item(MODE_END, SPAN_INNER, t1);
    end
    send_item(MODE_READ, SPAN_INNER, 32'd0);
    send_item(MODE_SPARE, SPAN_OUTER, 32'hFFFF_FFFF);
    send_item(MODE_END, SPAN_OUTER, 32'hFFFF_FFFF);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    wait_for_results();
    test_stack_limits();
    wait_for_results();
    test_random_trace(340);
    wait_for_results();
    test_large_spans();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d start, %0d end and %0d read transfers.",
             results_checked, n_starts, n_ends, n_reads);
    $display("Status seen: ok %0d, stack full %0d, stack empty %0d, total saturated %0d.",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (error_count == 0 && pending_totals.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("Timed out with %0d results still pending.", pending_totals.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
